// File: src/fmpd_pkg.sv
// Shared types, constants and elaboration-time functions for the FM phase discriminator.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package fmpd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W = 32;
  localparam int ANGLE_W = 19;
  localparam int LUT_W = 16;
  localparam int QUO_W = 17;
  localparam int TABLE_INDEX_BITS_DEFAULT = 8;
  localparam int QUARTER_PI = 25736;
  localparam int DIV_STEPS = 17;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int SERIES_BITS = 40;
  localparam int SERIES_TERMS = 80;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MUL4,
    S_ABS,
    S_SWAP,
    S_DIV,
    S_LUT_LO,
    S_LUT_HI,
    S_INTERP,
    S_ANGLE,
    S_OUT
  } state_t;

  // Steps of the shared multiplier that build the dot and cross products.
  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_RE_FIRST,
    MOP_RE_SECOND,
    MOP_IM_FIRST,
    MOP_IM_SECOND,
    MOP_IM_DONE
  } mul_op_t;

  typedef struct packed {
    logic    load_in;
    mul_op_t mul_op;
    logic    abs_en;
    logic    swap_en;
    logic    div_step;
    logic    lut_lo_en;
    logic    lut_hi_en;
    logic    interp_en;
    logic    angle_en;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  // Restoring long division on 64-bit constants; only evaluated at elaboration.
  function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] dv);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= dv) begin
        r = r - dv;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent table entry k: round(atan(k / 2^b) * 32768), by the exact series.
  function automatic logic [LUT_W-1:0] atan_entry(input int unsigned k, input int unsigned b);
    logic [63:0] k64;
    logic [63:0] k2;
    logic [63:0] den;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] rounded;
    k64 = 64'(k);
    k2 = k64 * k64;
    den = (64'd1 << (2 * b)) + k2;
    term = const_udiv((k64 << b) << SERIES_BITS, den);
    sum = term;
    for (int n = 1; n < SERIES_TERMS; n++) begin
      if (term != 64'd0) begin
        term = const_udiv(term * k2, den);
        term = const_udiv(term * 64'(2 * n), 64'(2 * n + 1));
        sum = sum + term;
      end
    end
    rounded = (sum * 64'd32768 + (64'd1 << (SERIES_BITS - 1))) >> SERIES_BITS;
    return rounded[LUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: src/fmpd_if.sv
// Valid/ready channel interfaces for the FM phase discriminator.
// Depends on fmpd_pkg for the field widths.
`default_nettype none

interface fmpd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [fmpd_pkg::SAMPLE_W-1:0]  i_sample;
  logic signed [fmpd_pkg::SAMPLE_W-1:0]  q_sample;

  modport source (output valid, output i_sample, output q_sample, input ready);
  modport sink (input valid, input i_sample, input q_sample, output ready);
endinterface

interface fmpd_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [fmpd_pkg::SAMPLE_W-1:0]  phase_delta;

  modport source (output valid, output phase_delta, input ready);
  modport sink (input valid, input phase_delta, output ready);
endinterface

`default_nettype wire

// File: src/fmpd_ctrl.sv
// Sequencing state machine of the FM phase discriminator.
// Depends on fmpd_pkg for the state, command and status types.
`default_nettype none

module fmpd_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  fmpd_pkg::dp_status_t    status,
  output fmpd_pkg::dp_cmd_t       cmd
);

  fmpd_pkg::state_t                state;
  fmpd_pkg::state_t                state_next;
  logic [fmpd_pkg::DIV_CNT_W-1:0]  cnt;
  logic                            div_last;

  assign div_last = (cnt == fmpd_pkg::DIV_CNT_W'(fmpd_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmpd_pkg::S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (state == fmpd_pkg::S_DIV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fmpd_pkg::S_IDLE: begin
        if (in_valid) state_next = fmpd_pkg::S_MUL0;
      end
      fmpd_pkg::S_MUL0:   state_next = fmpd_pkg::S_MUL1;
      fmpd_pkg::S_MUL1:   state_next = fmpd_pkg::S_MUL2;
      fmpd_pkg::S_MUL2:   state_next = fmpd_pkg::S_MUL3;
      fmpd_pkg::S_MUL3:   state_next = fmpd_pkg::S_MUL4;
      fmpd_pkg::S_MUL4:   state_next = fmpd_pkg::S_ABS;
      fmpd_pkg::S_ABS:    state_next = fmpd_pkg::S_SWAP;
      fmpd_pkg::S_SWAP:   state_next = fmpd_pkg::S_DIV;
      fmpd_pkg::S_DIV: begin
        if (div_last) state_next = fmpd_pkg::S_LUT_LO;
      end
      fmpd_pkg::S_LUT_LO: state_next = fmpd_pkg::S_LUT_HI;
      fmpd_pkg::S_LUT_HI: state_next = fmpd_pkg::S_INTERP;
      fmpd_pkg::S_INTERP: state_next = fmpd_pkg::S_ANGLE;
      fmpd_pkg::S_ANGLE:  state_next = fmpd_pkg::S_OUT;
      fmpd_pkg::S_OUT: begin
        // Wait until the output register is empty or being emptied.
        if (!status.out_busy) state_next = fmpd_pkg::S_IDLE;
      end
      default:            state_next = fmpd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      fmpd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load_in = in_valid;
      end
      fmpd_pkg::S_MUL0:   cmd.mul_op = fmpd_pkg::MOP_RE_FIRST;
      fmpd_pkg::S_MUL1:   cmd.mul_op = fmpd_pkg::MOP_RE_SECOND;
      fmpd_pkg::S_MUL2:   cmd.mul_op = fmpd_pkg::MOP_IM_FIRST;
      fmpd_pkg::S_MUL3:   cmd.mul_op = fmpd_pkg::MOP_IM_SECOND;
      fmpd_pkg::S_MUL4:   cmd.mul_op = fmpd_pkg::MOP_IM_DONE;
      fmpd_pkg::S_ABS:    cmd.abs_en = 1'b1;
      fmpd_pkg::S_SWAP:   cmd.swap_en = 1'b1;
      fmpd_pkg::S_DIV:    cmd.div_step = 1'b1;
      fmpd_pkg::S_LUT_LO: cmd.lut_lo_en = 1'b1;
      fmpd_pkg::S_LUT_HI: cmd.lut_hi_en = 1'b1;
      fmpd_pkg::S_INTERP: cmd.interp_en = 1'b1;
      fmpd_pkg::S_ANGLE:  cmd.angle_en = 1'b1;
      fmpd_pkg::S_OUT:    cmd.load_out = !status.out_busy;
      default:            cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: src/fmpd_datapath.sv
// Datapath of the FM phase discriminator: shared multiplier, octant fold, bit-serial
// divider, arctangent table with interpolation and the output register. Uses fmpd_pkg.
`default_nettype none

module fmpd_datapath #(
  parameter int TABLE_INDEX_BITS = fmpd_pkg::TABLE_INDEX_BITS_DEFAULT
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire signed [fmpd_pkg::SAMPLE_W-1:0]   i_sample,
  input  wire signed [fmpd_pkg::SAMPLE_W-1:0]   q_sample,
  input  fmpd_pkg::dp_cmd_t                     cmd,
  output fmpd_pkg::dp_status_t                  status,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic signed [fmpd_pkg::SAMPLE_W-1:0]  phase_delta
);

  localparam int FracBits = fmpd_pkg::LUT_W - TABLE_INDEX_BITS;
  localparam int TableSize = (1 << TABLE_INDEX_BITS) + 1;
  localparam int AddrW = TABLE_INDEX_BITS + 1;
  localparam int AngleW = fmpd_pkg::ANGLE_W;
  localparam int SampleW = fmpd_pkg::SAMPLE_W;
  localparam int LutW = fmpd_pkg::LUT_W;
  localparam int QuoW = fmpd_pkg::QUO_W;
  localparam int IpW = LutW + FracBits;
  localparam logic signed [AngleW-1:0] FullTurnOffset = AngleW'(4 * fmpd_pkg::QUARTER_PI);
  localparam logic signed [AngleW-1:0] HalfTurnOffset = AngleW'(2 * fmpd_pkg::QUARTER_PI);
  localparam logic signed [AngleW-1:0] OutMax = AngleW'(32767);
  localparam logic signed [AngleW-1:0] OutMin = -AngleW'(32768);

  logic [LutW-1:0] atan_rom [TableSize];

  for (genvar k = 0; k < TableSize; k++) begin : g_rom
    assign atan_rom[k] = fmpd_pkg::atan_entry(k, TABLE_INDEX_BITS);
  end

  logic signed [SampleW-1:0]         i_cur;
  logic signed [SampleW-1:0]         q_cur;
  logic signed [SampleW-1:0]         i_prev;
  logic signed [SampleW-1:0]         q_prev;
  logic signed [fmpd_pkg::PROD_W-1:0] prod;
  logic [fmpd_pkg::PROD_W-1:0]       re;
  logic [fmpd_pkg::PROD_W-1:0]       im;
  logic                              neg;
  logic signed [AngleW-1:0]          base;
  logic [LutW-1:0]                   rem;
  logic [LutW-1:0]                   den;
  logic [QuoW-1:0]                   dsh;
  logic [QuoW-1:0]                   quo;
  logic [TABLE_INDEX_BITS-1:0]       idx;
  logic [FracBits-1:0]               frac;
  logic [LutW-1:0]                   lut_lo;
  logic [LutW-1:0]                   lut_hi;
  logic [LutW-1:0]                   interp;
  logic signed [AngleW-1:0]          angle;

  logic signed [SampleW-1:0]          mul_a;
  logic signed [SampleW-1:0]          mul_b;
  logic signed [fmpd_pkg::PROD_W-1:0] mul_prod;
  logic [fmpd_pkg::PROD_W-1:0]        re_abs;
  logic [fmpd_pkg::PROD_W-1:0]        im_abs;
  logic                               swap;
  logic [fmpd_pkg::PROD_W-1:0]        mag_max;
  logic [fmpd_pkg::PROD_W-1:0]        mag_min;
  logic [QuoW-1:0]                    trial;
  logic [QuoW-1:0]                    trial_diff;
  logic                               trial_ge;
  logic [LutW-1:0]                    quot;
  logic [AddrW-1:0]                   hi_addr;
  logic [LutW-1:0]                    lut_diff;
  logic [IpW-1:0]                     ip;
  logic signed [AngleW-1:0]           angle_sum;
  logic signed [AngleW-1:0]           angle_adj;
  logic signed [AngleW-1:0]           angle_div;
  logic signed [SampleW-1:0]          result;

  always_comb begin
    unique case (cmd.mul_op)
      fmpd_pkg::MOP_RE_SECOND: begin
        mul_a = q_cur;
        mul_b = q_prev;
      end
      fmpd_pkg::MOP_IM_FIRST: begin
        mul_a = i_cur;
        mul_b = q_prev;
      end
      fmpd_pkg::MOP_IM_SECOND: begin
        mul_a = q_cur;
        mul_b = i_prev;
      end
      default: begin
        mul_a = i_cur;
        mul_b = i_prev;
      end
    endcase
  end

  assign mul_prod = mul_a * mul_b;

  // A wrapped minimum value negates to itself and reads as 2^31 unsigned.
  assign re_abs = re[fmpd_pkg::PROD_W-1] ? (~re + 1'b1) : re;
  assign im_abs = im[fmpd_pkg::PROD_W-1] ? (~im + 1'b1) : im;

  assign swap = (im >= re);
  assign mag_max = swap ? im : re;
  assign mag_min = swap ? re : im;

  // One quotient bit per step; with a non-zero divisor the partial remainder always stays below it.
  assign trial = {rem, dsh[QuoW-1]};
  assign trial_ge = (trial >= {1'b0, den});
  assign trial_diff = trial - {1'b0, den};

  // A zero divisor gives zero; a quotient of 2^16 or more is clamped.
  assign quot = (den == '0) ? '0 : (quo[QuoW-1] ? '1 : quo[LutW-1:0]);

  assign hi_addr = {1'b0, idx} + AddrW'(1);
  assign lut_diff = lut_hi - lut_lo;
  assign ip = IpW'(lut_diff) * IpW'(frac);

  assign angle_sum = base + $signed({{(AngleW - LutW){1'b0}}, lut_lo})
                   + $signed({{(AngleW - LutW){1'b0}}, interp});

  // Division by 16 rounds toward zero.
  assign angle_adj = angle + (angle[AngleW-1] ? AngleW'(15) : AngleW'(0));
  assign angle_div = angle_adj >>> 4;

  always_comb begin
    if (angle_div > OutMax) begin
      result = SampleW'(OutMax);
    end else if (angle_div < OutMin) begin
      result = SampleW'(OutMin);
    end else begin
      result = angle_div[SampleW-1:0];
    end
  end

  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      i_cur <= i_sample;
      q_cur <= q_sample;
    end

    case (cmd.mul_op)
      fmpd_pkg::MOP_RE_FIRST: begin
        prod <= mul_prod;
      end
      fmpd_pkg::MOP_RE_SECOND: begin
        re <= $unsigned(prod);
        prod <= mul_prod;
      end
      fmpd_pkg::MOP_IM_FIRST: begin
        re <= re + $unsigned(prod);
        prod <= mul_prod;
      end
      fmpd_pkg::MOP_IM_SECOND: begin
        im <= $unsigned(prod);
        prod <= mul_prod;
      end
      fmpd_pkg::MOP_IM_DONE: begin
        im <= im - $unsigned(prod);
      end
      default: begin
      end
    endcase

    if (cmd.abs_en) begin
      re <= re_abs;
      im <= im_abs;
      neg <= re[fmpd_pkg::PROD_W-1] ^ im[fmpd_pkg::PROD_W-1];
      base <= re[fmpd_pkg::PROD_W-1] ? -FullTurnOffset : '0;
    end

    if (cmd.swap_en) begin
      neg <= neg ^ swap;
      base <= swap ? (-base - HalfTurnOffset) : base;
      den <= mag_max[fmpd_pkg::PROD_W-1 -: LutW];
      rem <= {1'b0, mag_min[fmpd_pkg::PROD_W-1:QuoW]};
      dsh <= mag_min[QuoW-1:0];
      quo <= '0;
    end

    if (cmd.div_step) begin
      rem <= trial_ge ? trial_diff[LutW-1:0] : trial[LutW-1:0];
      quo <= {quo[QuoW-2:0], trial_ge};
      dsh <= {dsh[QuoW-2:0], 1'b0};
    end

    if (cmd.lut_lo_en) begin
      lut_lo <= atan_rom[{1'b0, quot[LutW-1:FracBits]}];
      idx <= quot[LutW-1:FracBits];
      frac <= quot[FracBits-1:0];
    end

    if (cmd.lut_hi_en) begin
      lut_hi <= atan_rom[hi_addr];
    end

    if (cmd.interp_en) begin
      interp <= LutW'(ip >> FracBits);
    end

    if (cmd.angle_en) begin
      angle <= neg ? -angle_sum : angle_sum;
    end

    if (cmd.load_out) begin
      phase_delta <= result;
    end

    if (rst) begin
      out_valid <= 1'b0;
      i_prev <= '0;
      q_prev <= '0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        i_prev <= i_cur;
        q_prev <= q_cur;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/fm_phase_discriminator_top.sv
// FM phase discriminator: one result per sample. A new sample is taken only once the
// sequencer is back in idle after the previous result has been loaded; the
// 17-step bit-serial divider and the shared 16x16 multiplier (five steps) set the pace.
// The output register lets the next sample in while a result waits to be taken.
// Synchronous reset clears the sequencer, the output valid flag and the stored
// previous sample (both halves zero).
`default_nettype none

module fm_phase_discriminator_top #(
  parameter int TABLE_INDEX_BITS = fmpd_pkg::TABLE_INDEX_BITS_DEFAULT
) (
  input wire         clk,
  input wire         rst,
  fmpd_in_if.sink    iq,
  fmpd_out_if.source phase
);

  fmpd_pkg::dp_cmd_t     cmd;
  fmpd_pkg::dp_status_t  status;
  logic                  in_ready;

  assign iq.ready = in_ready;

  fmpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (iq.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fmpd_datapath #(
    .TABLE_INDEX_BITS (TABLE_INDEX_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .i_sample    (iq.i_sample),
    .q_sample    (iq.q_sample),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (phase.valid),
    .out_ready   (phase.ready),
    .phase_delta (phase.phase_delta)
  );

endmodule

`default_nettype wire

// File: tb/fmpd_phase_checker.sv
// Checker for the FM phase discriminator: watches both channels, predicts each phase_delta
// from the accepted samples and compares it with the result transfers in order.
// Depends on fmpd_pkg and on the channel interfaces in fmpd_if.sv.
`default_nettype none

module fmpd_phase_checker #(
  parameter int TABLE_INDEX_BITS = fmpd_pkg::TABLE_INDEX_BITS_DEFAULT
) (
  input wire  clk,
  input wire  rst,
  fmpd_in_if  iq,
  fmpd_out_if phase,
  output int  fail_count,
  output int  pending
);

  localparam int FRAC_BITS = 16 - TABLE_INDEX_BITS;
  localparam int TAB_LAST = 1 << TABLE_INDEX_BITS;

  int atan_q15 [0:TAB_LAST];
  logic signed [15:0] last_i;
  logic signed [15:0] last_q;
  logic signed [15:0] expected_delta_q [$];

  // Arctangent of k / 2^TABLE_INDEX_BITS in Q15, summed from the exact integer series.
  function automatic int atan_series(input int unsigned k);
    longint unsigned k64;
    longint unsigned k2;
    longint unsigned den;
    longint unsigned term;
    longint unsigned sum;
    k64 = k;
    k2 = k64 * k64;
    den = (64'd1 << (2 * TABLE_INDEX_BITS)) + k2;
    term = ((k64 << TABLE_INDEX_BITS) << 40) / den;
    sum = term;
    for (int n = 1; n < 80 && term != 0; n++) begin
      term = term * k2 / den;
      term = term * longint'(2 * n) / longint'(2 * n + 1);
      sum = sum + term;
    end
    return int'((sum * 64'd32768 + (64'd1 << 39)) >> 40);
  endfunction

  function automatic logic signed [15:0] phase_delta_of(input logic signed [15:0] i1,
                                                        input logic signed [15:0] q1,
                                                        input logic signed [15:0] i0,
                                                        input logic signed [15:0] q0);
    logic [31:0] re;
    logic [31:0] im;
    logic [31:0] tmp;
    logic [31:0] divisor;
    logic [31:0] quo;
    logic [31:0] idx;
    logic [31:0] frac;
    logic [31:0] diff;
    int angle;
    int res;
    bit neg;
    re = 32'(int'(i1) * int'(i0) + int'(q1) * int'(q0));
    im = 32'(int'(i1) * int'(q0) - int'(q1) * int'(i0));
    angle = 0;
    neg = 1'b0;
    // Fold into the first octant; every fold flips the final sign.
    if (re[31]) begin
      re = 32'd0 - re;
      neg = ~neg;
      angle = angle - 4 * fmpd_pkg::QUARTER_PI;
    end
    if (im[31]) begin
      im = 32'd0 - im;
      neg = ~neg;
    end
    if (im >= re) begin
      tmp = im;
      im = re;
      re = tmp;
      neg = ~neg;
      angle = -angle - 2 * fmpd_pkg::QUARTER_PI;
    end
    divisor = re >> 16;
    quo = (divisor == 32'd0) ? 32'd0 : im / divisor;
    if (quo > 32'd65535) quo = 32'd65535;
    idx = (quo >> FRAC_BITS) & 32'(TAB_LAST - 1);
    frac = quo & 32'((1 << FRAC_BITS) - 1);
    diff = 32'(atan_q15[idx + 1] - atan_q15[idx]);
    angle = angle + atan_q15[idx] + int'((diff * frac) >> FRAC_BITS);
    if (neg) angle = -angle;
    res = angle / 16;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[15:0];
  endfunction

  initial begin
    for (int k = 0; k <= TAB_LAST; k++) atan_q15[k] = atan_series(k);
  end

  always @(posedge clk) begin : watch
    logic signed [15:0] want;
    if (rst) begin
      last_i <= '0;
      last_q <= '0;
      expected_delta_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (phase.valid && phase.ready) begin
        if (expected_delta_q.size() == 0) begin
          $error("phase_delta transfer with nothing expected: actual %0d", phase.phase_delta);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_delta_q.pop_front();
          if (phase.phase_delta !== want) begin
            $error("phase_delta mismatch: expected %0d actual %0d", want, phase.phase_delta);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (iq.valid && iq.ready) begin
        expected_delta_q.push_back(phase_delta_of(iq.i_sample, iq.q_sample, last_i, last_q));
        last_i <= iq.i_sample;
        last_q <= iq.q_sample;
      end
      pending <= expected_delta_q.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_fm_phase_discriminator_top.sv
// Top of the FM phase discriminator testbench: clock, reset, sample stimulus, result-side
// back-pressure, a stall watchdog and the verdict. Depends on fmpd_pkg, fmpd_if.sv, the
// block and the checker in fmpd_phase_checker.sv.
`default_nettype none

module tb_fm_phase_discriminator_top;

  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_SAMPLES = 1150;
  localparam int HOLD_START = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;

  logic clk;
  logic rst;
  int fail_count;
  int pending;

  fmpd_in_if iq ();
  fmpd_out_if phase ();

  fm_phase_discriminator_top u_top (
    .clk   (clk),
    .rst   (rst),
    .iq    (iq),
    .phase (phase)
  );

  fmpd_phase_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .iq         (iq),
    .phase      (phase),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_sample(input logic signed [15:0] i_val, input logic signed [15:0] q_val);
    iq.valid <= 1'b1;
    iq.i_sample <= i_val;
    iq.q_sample <= q_val;
    do @(posedge clk); while (!iq.ready);
  endtask

  task automatic sender_gap(input int cycles);
    iq.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic signed [15:0] corner_value();
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  // Result side: random stalls, one long hold-off so the block backs up into its input,
  // and a long stretch where every result is taken at once.
  initial begin
    int cyc;
    cyc = 0;
    phase.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
        phase.ready <= 1'b0;
      else if (cyc >= 20000 && cyc < 26000)
        phase.ready <= 1'b1;
      else
        phase.ready <= ($urandom_range(0, 99) >= 24);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((iq.valid && iq.ready) || (phase.valid && phase.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_fm_phase_discriminator_top NOT OK");
    $finish;
  end

  initial begin
    logic signed [15:0] corner_i [24];
    logic signed [15:0] corner_q [24];
    logic signed [15:0] next_i;
    logic signed [15:0] next_q;
    logic signed [15:0] prev_i;
    logic signed [15:0] prev_q;
    int offset;

    // All-zero start, full-scale equal samples, the dot product wrapping to -2^31,
    // opposite corners, an equal-magnitude pair that clamps the quotient, a quarter
    // turn that swaps the products, and tiny samples that leave a zero divisor.
    corner_i = '{16'sd0, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768,
                 16'sd32767, 16'sd4, 16'sd30000, 16'sd0, -16'sd32768, 16'sd1,
                 16'sd0, 16'sd1, -16'sd1, 16'sd100, -16'sd7000, 16'sd12345,
                 -16'sd1, 16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 16'sd0};
    corner_q = '{16'sd0, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
                 -16'sd32768, 16'sd0, -16'sd30000, -16'sd32768, 16'sd0, 16'sd0,
                 16'sd1, 16'sd1, -16'sd1, -16'sd50, 16'sd20000, -16'sd23456,
                 16'sd0, -16'sd1, 16'sd0, 16'sd32767, -16'sd32768, 16'sd0};

    rst <= 1'b1;
    iq.valid <= 1'b0;
    iq.i_sample <= '0;
    iq.q_sample <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < 24; n++) begin
      send_sample(corner_i[n], corner_q[n]);
      if ($urandom_range(0, 99) < 24) sender_gap($urandom_range(1, 40));
    end
    prev_i = corner_i[23];
    prev_q = corner_q[23];

    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      if (n == 300) begin
        // Let the pipeline drain completely before continuing.
        iq.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      case ($urandom_range(0, 9))
        6: begin
          offset = $urandom_range(0, 600) - 300;
          next_i = 16'(offset);
          offset = $urandom_range(0, 600) - 300;
          next_q = 16'(offset);
        end
        7: begin
          next_i = prev_q;
          next_q = -prev_i;
        end
        8: begin
          next_i = prev_i;
          next_q = prev_q;
        end
        9: begin
          next_i = corner_value();
          next_q = corner_value();
        end
        default: begin
          next_i = 16'($urandom);
          next_q = 16'($urandom);
        end
      endcase
      send_sample(next_i, next_q);
      prev_i = next_i;
      prev_q = next_q;
      if ((n < 600 || n >= 900) && $urandom_range(0, 99) < 24)
        sender_gap($urandom_range(1, 40));
    end

    iq.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("tb_fm_phase_discriminator_top OK");
    end else begin
      $display("tb_fm_phase_discriminator_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
